>>> hw/rtl/nsfc_pkg.sv
// Shared types, constants and helper functions for the NMEA sentence framer/checker.
`default_nettype none
package nsfc_pkg;

  localparam int BUFFER_BYTES_DEF = 128;
  localparam int QDEPTH           = 2;   // power of two
  localparam int QW               = $clog2(QDEPTH);
  localparam int IN_DATA_W        = 16;
  localparam int OUT_DATA_W       = 16;
  localparam int LEN_W            = 7;
  localparam int IDX_W            = 7;
  localparam int TAG_W            = 40;
  localparam int SENT_HDR_LEN     = 6;

  localparam logic [TAG_W-1:0] TAG_RESET = 40'h4750474741;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_ARM  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_ARM  = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_t;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] read_index;
    logic             is_dollar;
    logic             is_lf;
  } cmd_t;

  // Tag byte at sentence position 1..5, first tag byte in the top bits.
  function automatic logic [7:0] tag_byte(input logic [TAG_W-1:0] tag, input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd1:    b = tag[39:32];
      3'd2:    b = tag[31:24];
      3'd3:    b = tag[23:16];
      3'd4:    b = tag[15:8];
      3'd5:    b = tag[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // {valid, value} of an ASCII hex digit, either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/nsfc_front.sv
// Front end: accepts input items, classifies them and queues commands for the back end.
`default_nettype none
module nsfc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [nsfc_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]                   in_tuser,
  output logic                              q_valid,
  output nsfc_pkg::cmd_t                    q_cmd,
  input  wire logic                         q_pop
);
  import nsfc_pkg::*;

  cmd_t          cmd;
  logic          keep;
  logic          push;
  cmd_t          q_mem_r [QDEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QW:0]   count_r, count_nxt;

  always_comb begin
    cmd.kind       = CMD_BYTE;
    cmd.rx_byte    = in_tdata[7:0];
    cmd.read_index = in_tdata[14:8];
    cmd.is_dollar  = in_tdata[7:0] == CH_DOLLAR;
    cmd.is_lf      = in_tdata[7:0] == CH_LF;
    keep           = 1'b0;
    unique case (op_e_t'(in_tuser))
      OP_BYTE: begin
        cmd.kind = CMD_BYTE;
        keep     = in_tdata[7:0] != CH_CR;
      end
      OP_ARM: begin
        cmd.kind = CMD_ARM;
        keep     = 1'b1;
      end
      OP_READ: begin
        cmd.kind = CMD_READ;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = count_r != (QW+1)'(QDEPTH);
  assign q_valid   = count_r != '0;
  assign q_cmd     = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready && keep;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) count_nxt = count_r + 1'b1;
    else if (!push && q_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cmd;
  end

endmodule
`default_nettype wire

>>> hw/rtl/nsfc_back.sv
// Back end: sentence state, checksum/tag tracking, sentence store and output register.
`default_nettype none
module nsfc_back #(
  parameter int BUFFER_BYTES = nsfc_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wen,
  input  wire logic [nsfc_pkg::TAG_W-1:0]      cfg_wdata,
  input  wire logic                          q_valid,
  input  wire nsfc_pkg::cmd_t                q_cmd,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [nsfc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                               out_tuser
);
  import nsfc_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  logic [TAG_W-1:0] tag_r;
  logic             armed_r, armed_nxt;
  logic             collecting_r, collecting_nxt;
  logic [AW-1:0]    fill_r, fill_nxt;
  logic [AW-1:0]    text_end_r, text_end_nxt;
  logic             zero_seen_r, zero_seen_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             star_seen_r, star_seen_nxt;
  logic [7:0]       star_xor_r, star_xor_nxt;
  logic [AW-1:0]    star_pos_r, star_pos_nxt;
  logic             tag_match_r, tag_match_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [7:0]       lo_r, lo_nxt;

  logic [7:0]       mem [BUFFER_BYTES];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AW+IDX_W-1:0] ridx_w;
  logic [AW-1:0]    raddr;
  logic             rd_in_range;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [LEN_W-1:0] out_len_r;
  logic [7:0]       out_byte_r;

  logic [AW-1:0]    len;
  logic             tag_ok;
  logic [4:0]       hex_hi, hex_lo;
  logic             sent_ok;
  logic             is_read, accept_lf, need_out, out_free;
  logic [AW+LEN_W-1:0] fill_w;
  logic [LEN_W-1:0] fill_len;
  logic [7:0]       b;

  assign b = q_cmd.rx_byte;

  // Checksum and tag verdict for the sentence collected so far.
  always_comb begin
    len    = zero_seen_r ? text_end_r : fill_r;
    tag_ok = tag_match_r && (len >= AW'(SENT_HDR_LEN) || zero_seen_r ||
                             tag_byte(tag_r, len[2:0]) == 8'h00);
    hex_hi = hex_digit(hi_r);
    hex_lo = hex_digit(lo_r);
    sent_ok = tag_ok && star_seen_r &&
              (({1'b0, star_pos_r} + (AW+1)'(2)) < {1'b0, len}) &&
              hex_hi[4] && hex_lo[4] && ({hex_hi[3:0], hex_lo[3:0]} == star_xor_r);
  end

  assign fill_w   = {{LEN_W{1'b0}}, fill_r};
  assign fill_len = fill_w[LEN_W-1:0];
  assign ridx_w   = {{AW{1'b0}}, q_cmd.read_index};
  assign raddr    = ridx_w[AW-1:0];
  assign rd_in_range = 32'(q_cmd.read_index) < BUFFER_BYTES;

  assign out_free  = !out_valid_r || out_tready;
  assign is_read   = q_cmd.kind == CMD_READ;
  assign accept_lf = q_cmd.kind == CMD_BYTE && armed_r && collecting_r && q_cmd.is_lf && sent_ok;
  assign need_out  = is_read || accept_lf;
  assign q_pop     = q_valid && (!need_out || out_free);

  always_comb begin
    armed_nxt      = armed_r;
    collecting_nxt = collecting_r;
    fill_nxt       = fill_r;
    text_end_nxt   = text_end_r;
    zero_seen_nxt  = zero_seen_r;
    xor_nxt        = xor_r;
    star_seen_nxt  = star_seen_r;
    star_xor_nxt   = star_xor_r;
    star_pos_nxt   = star_pos_r;
    tag_match_nxt  = tag_match_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_r;
    mem_wdata      = b;
    if (q_pop) begin
      unique case (q_cmd.kind)
        CMD_ARM: begin
          armed_nxt = 1'b1;
        end
        CMD_READ: begin
          armed_nxt = armed_r;
        end
        CMD_BYTE: begin
          if (armed_r) begin
            if (!collecting_r) begin
              if (q_cmd.is_dollar) begin
                collecting_nxt = 1'b1;
                text_end_nxt   = '0;
                zero_seen_nxt  = 1'b0;
                xor_nxt        = 8'h00;
                star_seen_nxt  = 1'b0;
                star_xor_nxt   = 8'h00;
                star_pos_nxt   = '0;
                tag_match_nxt  = 1'b1;
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata      = CH_DOLLAR;
                fill_nxt       = AW'(1);
              end
            end else if (q_cmd.is_lf) begin
              collecting_nxt = 1'b0;
              fill_nxt       = '0;
              if (sent_ok) armed_nxt = 1'b0;
            end else if (fill_r < AW'(BUFFER_BYTES - 1)) begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + 1'b1;
              if (star_seen_r && fill_r == star_pos_r + AW'(1)) hi_nxt = b;
              if (star_seen_r && fill_r == star_pos_r + AW'(2)) lo_nxt = b;
              if (!zero_seen_r) begin
                if (fill_r != '0 && fill_r < AW'(SENT_HDR_LEN) &&
                    b != tag_byte(tag_r, fill_r[2:0])) begin
                  tag_match_nxt = 1'b0;
                end
                if (b == 8'h00) begin
                  zero_seen_nxt = 1'b1;
                  text_end_nxt  = fill_r;
                end else begin
                  if (b == CH_STAR) begin
                    star_seen_nxt = 1'b1;
                    star_pos_nxt  = fill_r;
                    star_xor_nxt  = xor_r;
                  end
                  xor_nxt = xor_r ^ b;
                end
              end
            end else begin
              collecting_nxt = 1'b0;
              fill_nxt       = '0;
            end
          end
        end
        default: begin
          armed_nxt = armed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r        <= TAG_RESET;
      armed_r      <= 1'b0;
      collecting_r <= 1'b0;
      fill_r       <= '0;
      text_end_r   <= '0;
      zero_seen_r  <= 1'b0;
      xor_r        <= 8'h00;
      star_seen_r  <= 1'b0;
      star_xor_r   <= 8'h00;
      star_pos_r   <= '0;
      tag_match_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wen) tag_r <= cfg_wdata;
      armed_r      <= armed_nxt;
      collecting_r <= collecting_nxt;
      fill_r       <= fill_nxt;
      text_end_r   <= text_end_nxt;
      zero_seen_r  <= zero_seen_nxt;
      xor_r        <= xor_nxt;
      star_seen_r  <= star_seen_nxt;
      star_xor_r   <= star_xor_nxt;
      star_pos_r   <= star_pos_nxt;
      tag_match_r  <= tag_match_nxt;
      if (out_free) out_valid_r <= q_pop && need_out;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  // Sentence store: one write port, one registered read into the output register.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (out_free && q_pop && need_out) begin
      out_kind_r <= is_read ? KIND_READ : KIND_REPORT;
      out_len_r  <= is_read ? '0 : fill_len;
      out_byte_r <= (is_read && rd_in_range) ? mem[raddr] : 8'h00;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_byte_r, out_len_r};

endmodule
`default_nettype wire

>>> hw/rtl/nmea_sentence_framer_checker.sv
// NMEA sentence framer/checker: top level joining front end, command queue and back end.
//
// Input channel (in_*): one item per handshake. in_tuser holds the operation (received
// byte, arm, read stored byte); in_tdata holds the byte and the read index.
// Output channel (out_*): one item per accepted sentence report or per read.
// Configuration: cfg_wen writes the 40-bit sentence tag from cfg_wdata;
// write it only while the block is idle.
// Throughput: one input item per cycle as long as the output side keeps up. Items that
// give no result pass even while the output is stalled, unless a result item heads the queue;
// a two-entry command queue decouples the front end from the back end.
// Result path: an accepted item is written into a queue entry; when the back end pops it, the
// output register (holding the registered store read) takes the result shown on out_*.
// Reset: synchronous, active low; the block comes up disarmed with the GPGGA tag and an
// empty queue, and waits for an arm item. The sentence store is not cleared.
// Output stall: the result holds in the output register; the back end keeps working on items
// with no result until a result item heads the queue; in_tready drops only when it is full.
`default_nettype none
module nmea_sentence_framer_checker #(
  parameter int BUFFER_BYTES = nsfc_pkg::BUFFER_BYTES_DEF  // 16..128
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wen,
  input  wire logic [nsfc_pkg::TAG_W-1:0]        cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [nsfc_pkg::IN_DATA_W-1:0]    in_tdata,  // rx_byte[7:0], read_index[14:8]
  input  wire logic [1:0]                      in_tuser,  // operation[1:0]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [nsfc_pkg::OUT_DATA_W-1:0]        out_tdata, // sentence_length[6:0], data_byte[14:7]
  output logic                                 out_tuser  // result_kind[0]
);
  import nsfc_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  nsfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  nsfc_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

>>> hw/rtl/nsfc_checker.sv
// Port-level assertions for the NMEA sentence framer/checker, bound to the top level.
`default_nettype none
module nsfc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [nsfc_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tuser
);
  import nsfc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input blocked after reset");

  a_read_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_READ |-> out_tdata[6:0] == 7'd0)
    else $error("read result carries a sentence length");

  a_report_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REPORT |-> out_tdata[15:7] == 9'd0)
    else $error("sentence report carries a data byte");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (.*);
`default_nettype wire
